FILE: hdl/fcmc_pkg.sv
// fcmc_pkg: shared types and constants for the fan cooling controller
// holds mode codes, duty levels, threshold defaults and the scaling constant
// no dependencies
`default_nettype none

package fcmc_pkg;

  // controller mode codes
  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_COOLING  = 2'd1;
  localparam logic [1:0] MODE_OVERHEAT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_COOL_ON  = 2'd0;
  localparam logic [1:0] CFG_MID      = 2'd1;
  localparam logic [1:0] CFG_HIGH     = 2'd2;
  localparam logic [1:0] CFG_OVERHEAT = 2'd3;

  // field widths
  localparam int SampleW = 12;
  localparam int TempW   = 12;
  localparam int DutyW   = 7;

  // fan duty levels in percent
  localparam logic [DutyW-1:0] DUTY_OFF  = 7'd0;
  localparam logic [DutyW-1:0] DUTY_LOW  = 7'd33;
  localparam logic [DutyW-1:0] DUTY_MID  = 7'd66;
  localparam logic [DutyW-1:0] DUTY_FULL = 7'd100;

  // threshold defaults in tenths of a degree
  localparam logic [TempW-1:0] COOL_ON_RST  = 12'd250;
  localparam logic [TempW-1:0] MID_RST      = 12'd300;
  localparam logic [TempW-1:0] HIGH_RST     = 12'd350;
  localparam logic [TempW-1:0] OVERHEAT_RST = 12'd400;

  // sample * 3300 / 4095 == (sample * ScaleMult) >> ScaleShift for every 12-bit sample
  localparam int ScaleShift = 21;
  localparam int ScaleMultW = 21;
  localparam logic [ScaleMultW-1:0] SCALE_MULT = 21'd1690013;
  localparam int ProdW = SampleW + ScaleMultW;

  // threshold set
  typedef struct packed {
    logic [TempW-1:0] cool_on;
    logic [TempW-1:0] mid;
    logic [TempW-1:0] high;
    logic [TempW-1:0] overheat;
  } fcmc_thr_t;

  // one result plus the next controller state
  typedef struct packed {
    logic [TempW-1:0] temp_tenths;
    logic [DutyW-1:0] fan_duty;
    logic             alarm;
    logic [1:0]       mode;
  } fcmc_result_t;

endpackage

`default_nettype wire

FILE: hdl/fcmc_step.sv
// fcmc_step: scaling of one sample and the mealy transition of the controller
// purely combinational; uses fcmc_pkg
`default_nettype none

module fcmc_step (
  input  logic [fcmc_pkg::SampleW-1:0] sample_i,
  input  fcmc_pkg::fcmc_thr_t          thr_i,
  input  logic [1:0]                   mode_i,
  input  logic                         alarm_i,
  output fcmc_pkg::fcmc_result_t       res_o
);
  import fcmc_pkg::*;

  logic [ProdW-1:0] prod;
  logic [TempW-1:0] temp;
  logic [DutyW-1:0] step_duty;
  logic             below_cool;
  logic             below_over;

  // scale to tenths of a degree by a reciprocal multiply
  assign prod = ProdW'(sample_i) * ProdW'(SCALE_MULT);
  assign temp = prod[ScaleShift +: TempW];

  assign below_cool = (temp < thr_i.cool_on);
  assign below_over = (temp < thr_i.overheat);

  // step duty, first threshold that the reading is below decides
  always_comb begin
    priority if (below_cool) begin
      step_duty = DUTY_OFF;
    end else if (temp < thr_i.mid) begin
      step_duty = DUTY_LOW;
    end else if (temp < thr_i.high) begin
      step_duty = DUTY_MID;
    end else begin
      step_duty = DUTY_FULL;
    end
  end

  // mealy transition
  always_comb begin
    res_o.temp_tenths = temp;
    res_o.fan_duty    = DUTY_OFF;
    res_o.alarm       = alarm_i;
    res_o.mode        = mode_i;
    unique case (mode_i)
      MODE_COOLING: begin
        if (below_cool) begin
          res_o.fan_duty = DUTY_OFF;
          res_o.mode     = MODE_IDLE;
        end else if (!below_over) begin
          res_o.fan_duty = DUTY_FULL;
          res_o.alarm    = 1'b1;
          res_o.mode     = MODE_OVERHEAT;
        end else begin
          res_o.fan_duty = step_duty;
        end
      end
      MODE_OVERHEAT: begin
        if (below_over) begin
          res_o.alarm    = 1'b0;
          res_o.fan_duty = step_duty;
          res_o.mode     = MODE_COOLING;
        end else begin
          res_o.fan_duty = DUTY_FULL;
        end
      end
      default: begin
        // idle, and the unused code behaves as idle
        if (!below_cool) begin
          res_o.fan_duty = step_duty;
          res_o.mode     = MODE_COOLING;
        end else begin
          res_o.fan_duty = DUTY_OFF;
          res_o.mode     = MODE_IDLE;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/fan_cooling_mealy_controller_unit.sv
// fan_cooling_mealy_controller_unit: top level of the fan cooling controller
// sample register, threshold registers, controller state and result register
// depends on fcmc_pkg and fcmc_step
`default_nettype none

// Takes one raw 12-bit sensor sample per transfer and returns one result per
// sample: the temperature in tenths of a degree (sample*3300/4095, rounded
// down), the fan duty (0, 33, 66 or 100 percent), the alarm flag and the
// controller mode after the sample (0 idle, 1 cooling, 2 overheat). One sample
// is taken every cycle while the result side does not stall. The transfer edge
// loads the sample register; scaling and the state decision run combinationally
// on the registered sample, and the result register loads from them once it is
// empty or drained. A stalled result holds the pending sample and stalls the
// input. Thresholds come out of reset at 250, 300, 350 and 400; they are to be
// written through the cfg port only while no sample is in flight, which the
// block itself does not enforce.

module fan_cooling_mealy_controller_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [fcmc_pkg::SampleW-1:0]  adc_sample_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fcmc_pkg::TempW-1:0]    temp_tenths_o,
  output logic [fcmc_pkg::DutyW-1:0]    fan_duty_o,
  output logic                          alarm_o,
  output logic [1:0]                    mode_o,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [fcmc_pkg::TempW-1:0]    cfg_data_i
);
  import fcmc_pkg::*;

  logic                in_valid_q;
  logic [SampleW-1:0]  sample_q;
  logic                out_valid_q;
  fcmc_result_t        res_q;
  fcmc_result_t        res_d;
  fcmc_thr_t           thr_q;
  logic [1:0]          mode_q;
  logic                alarm_q;
  logic                out_load;
  logic                in_load;

  // handshake, the result register loads when a sample is pending and it is empty or drained
  assign out_load   = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !out_load;
  assign in_load    = in_valid_i && !in_stall_o;

  // sample register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= 1'b1;
    end else if (out_load) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      sample_q <= adc_sample_i;
    end
  end

  // threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.cool_on  <= COOL_ON_RST;
      thr_q.mid      <= MID_RST;
      thr_q.high     <= HIGH_RST;
      thr_q.overheat <= OVERHEAT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_COOL_ON:  thr_q.cool_on  <= cfg_data_i;
        CFG_MID:      thr_q.mid      <= cfg_data_i;
        CFG_HIGH:     thr_q.high     <= cfg_data_i;
        CFG_OVERHEAT: thr_q.overheat <= cfg_data_i;
        default:      thr_q          <= thr_q;
      endcase
    end
  end

  // scaling and state decision
  fcmc_step u_step (
    .sample_i (sample_q),
    .thr_i    (thr_q),
    .mode_i   (mode_q),
    .alarm_i  (alarm_q),
    .res_o    (res_d)
  );

  // controller state advances with each result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      alarm_q <= 1'b0;
    end else if (out_load) begin
      mode_q  <= res_d.mode;
      alarm_q <= res_d.alarm;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign temp_tenths_o = res_q.temp_tenths;
  assign fan_duty_o    = res_q.fan_duty;
  assign alarm_o       = res_q.alarm;
  assign mode_o        = res_q.mode;

  // alarm is on exactly in overheat
  a_alarm_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    alarm_q == (mode_q == MODE_OVERHEAT))
    else $error("alarm flag out of step with overheat mode");

  // unused mode code never reached
  a_mode_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_IDLE) || (mode_q == MODE_COOLING) || (mode_q == MODE_OVERHEAT))
    else $error("controller in unused mode code");

  // overheat results always drive the fan fully
  a_overheat_duty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mode_o == MODE_OVERHEAT) |-> (fan_duty_o == DUTY_FULL))
    else $error("overheat result without full duty");

  // state moves only with a result
  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_load |=> ($stable(mode_q) && $stable(alarm_q)))
    else $error("controller state changed without a result");

  // a blocked sample is kept
  a_sample_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && out_stall_i) |=> in_valid_q)
    else $error("pending sample dropped under stall");

endmodule

`default_nettype wire

FILE: tb/tb_fan_cooling_mealy_controller_unit.sv
// tb_fan_cooling_mealy_controller_unit: self-checking testbench for the fan cooling controller
// drives directed and random sensor samples and threshold writes, checks every result
// against its own model of the controller; depends on fcmc_pkg and the controller top level
`timescale 1ns / 1ps

module tb_fan_cooling_mealy_controller_unit;
  import fcmc_pkg::*;

  localparam int CycleLimit     = 400000;
  localparam int MaxPrinted     = 40;
  localparam int BlockItems     = 146;
  localparam int BlocksPerPhase = 4;
  localparam int TempMax        = 3300;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [SampleW-1:0]   adc_sample_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [TempW-1:0]     temp_tenths_o;
  logic [DutyW-1:0]     fan_duty_o;
  logic                 alarm_o;
  logic [1:0]           mode_o;
  logic                 cfg_we_i;
  logic [1:0]           cfg_index_i;
  logic [TempW-1:0]     cfg_data_i;

  fan_cooling_mealy_controller_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .adc_sample_i  (adc_sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .temp_tenths_o (temp_tenths_o),
    .fan_duty_o    (fan_duty_o),
    .alarm_o       (alarm_o),
    .mode_o        (mode_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // controller model state and threshold copy
  fcmc_thr_t    thr_model;
  logic [1:0]   mode_model;
  logic         alarm_model;

  fcmc_result_t pending_results[$];

  int           tx_idle_pct;
  int           rx_stall_pct;
  int           mismatch_count;
  int           samples_sent;
  int           results_checked;
  int           settings_used;
  int           cycle_count;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // receiver stall
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted)
      $display("mismatch at result %0d: %s got %0d, expected %0d", results_checked, what, got,
               want);
  endtask

  // step duty from the thresholds, first threshold not reached decides
  function automatic logic [DutyW-1:0] duty_for_temp(input int t);
    if (t < int'(thr_model.cool_on)) return DUTY_OFF;
    if (t < int'(thr_model.mid)) return DUTY_LOW;
    if (t < int'(thr_model.high)) return DUTY_MID;
    return DUTY_FULL;
  endfunction

  // one controller step, advances the model state
  function automatic fcmc_result_t predict_controller(input logic [SampleW-1:0] sample);
    fcmc_result_t r;
    int           t;
    logic [DutyW-1:0] duty;
    t = (int'(sample) * 3300) / 4095;
    case (mode_model)
      MODE_COOLING: begin
        if (t < int'(thr_model.cool_on)) begin
          duty = DUTY_OFF;
          mode_model = MODE_IDLE;
        end else if (t >= int'(thr_model.overheat)) begin
          duty = DUTY_FULL;
          alarm_model = 1'b1;
          mode_model = MODE_OVERHEAT;
        end else begin
          duty = duty_for_temp(t);
        end
      end
      MODE_OVERHEAT: begin
        if (t < int'(thr_model.overheat)) begin
          alarm_model = 1'b0;
          duty = duty_for_temp(t);
          mode_model = MODE_COOLING;
        end else begin
          duty = DUTY_FULL;
        end
      end
      default: begin
        if (t >= int'(thr_model.cool_on)) begin
          duty = duty_for_temp(t);
          mode_model = MODE_COOLING;
        end else begin
          duty = DUTY_OFF;
          mode_model = MODE_IDLE;
        end
      end
    endcase
    r.temp_tenths = t[TempW-1:0];
    r.fan_duty    = duty;
    r.alarm       = alarm_model;
    r.mode        = mode_model;
    return r;
  endfunction

  // smallest sample that scales to the given temperature
  function automatic logic [SampleW-1:0] sample_for_temp(input int t);
    int c;
    c = (t < 0) ? 0 : ((t > TempMax) ? TempMax : t);
    return SampleW'((c * 4095 + TempMax - 1) / TempMax);
  endfunction

  // one sample transfer, with an optional idle gap in front
  task automatic send_sample(input logic [SampleW-1:0] sample);
    int gap;
    gap = 0;
    if ($urandom_range(99) < tx_idle_pct) gap = $urandom_range(1, 3);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    adc_sample_i <= sample;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_controller(sample));
    samples_sent++;
  endtask

  // stop sending and wait until every result is back and the pipeline is empty
  task automatic drain_results;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [1:0] idx, input logic [TempW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_COOL_ON:  thr_model.cool_on  = val;
      CFG_MID:      thr_model.mid      = val;
      CFG_HIGH:     thr_model.high     = val;
      CFG_OVERHEAT: thr_model.overheat = val;
      default: ;
    endcase
  endtask

  task automatic write_all_thresholds(input int c, input int m, input int h, input int o);
    drain_results();
    write_threshold(CFG_COOL_ON, TempW'(c));
    write_threshold(CFG_MID, TempW'(m));
    write_threshold(CFG_HIGH, TempW'(h));
    write_threshold(CFG_OVERHEAT, TempW'(o));
    settings_used++;
  endtask

  // result checker
  always @(posedge clk_i) begin : check_results
    fcmc_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, temp", int'(temp_tenths_o), -1);
      end else begin
        want = pending_results.pop_front();
        if (temp_tenths_o !== want.temp_tenths)
          report_mismatch("temp_tenths", int'(temp_tenths_o), int'(want.temp_tenths));
        if (fan_duty_o !== want.fan_duty)
          report_mismatch("fan_duty", int'(fan_duty_o), int'(want.fan_duty));
        if (alarm_o !== want.alarm)
          report_mismatch("alarm", int'(alarm_o), int'(want.alarm));
        if (mode_o !== want.mode)
          report_mismatch("mode", int'(mode_o), int'(want.mode));
      end
      results_checked++;
    end
  end

  // walk through every transition with the reset thresholds
  task automatic test_default_thresholds;
    send_sample(12'd0);                  // idle stays idle
    send_sample(sample_for_temp(249));   // just below fan start
    send_sample(sample_for_temp(250));   // idle to cooling, low duty
    send_sample(sample_for_temp(300));   // mid duty
    send_sample(sample_for_temp(350));   // full duty
    send_sample(sample_for_temp(399));   // full duty, still cooling
    send_sample(sample_for_temp(400));   // cooling to overheat, alarm on
    send_sample(12'd4095);               // overheat holds
    send_sample(sample_for_temp(399));   // back to cooling, alarm off
    send_sample(sample_for_temp(400));   // overheat again
    send_sample(sample_for_temp(100));   // overheat below fan start goes to cooling
    send_sample(sample_for_temp(100));   // then idle
    send_sample(12'd4095);               // idle jumps to cooling at full duty, no alarm
    send_sample(12'd4095);               // then overheat
    send_sample(12'd0);                  // overheat to cooling with duty off
    send_sample(12'd0);                  // cooling to idle
  endtask

  // thresholds out of order and one above the scaled range
  task automatic test_unordered_thresholds;
    write_all_thresholds(500, 200, 100, 4095);
    send_sample(sample_for_temp(499));
    send_sample(sample_for_temp(500));
    send_sample(12'd4095);               // overheat never reached
    send_sample(sample_for_temp(100));
  endtask

  // all thresholds at zero, then all at the top of the register
  task automatic test_threshold_extremes;
    write_all_thresholds(0, 0, 0, 0);
    send_sample(12'd0);                  // idle to cooling at full duty
    send_sample(12'd0);                  // cooling to overheat
    send_sample(12'd0);                  // overheat holds
    write_all_thresholds(4095, 4095, 4095, 4095);
    send_sample(12'd4095);               // overheat releases with duty off
    send_sample(12'd4095);               // cooling to idle
  endtask

  // random threshold set, mostly ordered within the scaled range
  task automatic pick_random_thresholds;
    int v[$];
    v = {};
    if ($urandom_range(99) < 75) begin
      repeat (4) v.push_back($urandom_range(0, TempMax));
      v.sort();
    end else begin
      repeat (4) v.push_back($urandom_range(0, 4095));
    end
    write_all_thresholds(v[0], v[1], v[2], v[3]);
  endtask

  // samples clustered around the thresholds, plus uniform and extreme ones
  function automatic logic [SampleW-1:0] pick_random_sample;
    int r;
    int base;
    r = $urandom_range(99);
    if (r < 55) begin
      case ($urandom_range(3))
        0:       base = int'(thr_model.cool_on);
        1:       base = int'(thr_model.mid);
        2:       base = int'(thr_model.high);
        default: base = int'(thr_model.overheat);
      endcase
      return sample_for_temp(base + $urandom_range(0, 6) - 3);
    end
    if (r < 85) return SampleW'($urandom_range(0, 4095));
    if (r < 93) return SampleW'(($urandom_range(1) != 0) ? 4095 : 0);
    return sample_for_temp($urandom_range(0, 60));
  endfunction

  task automatic test_random_samples;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct  = 30;
          rx_stall_pct = 46;
        end
        1: begin
          tx_idle_pct  = 46;
          rx_stall_pct = 30;
        end
        default: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
      endcase
      for (int blk = 0; blk < BlocksPerPhase; blk++) begin
        pick_random_thresholds();
        repeat (BlockItems) send_sample(pick_random_sample());
      end
    end
  endtask

  // main sequence
  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    adc_sample_i    = '0;
    out_stall_i     = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = CFG_COOL_ON;
    cfg_data_i      = '0;
    tx_idle_pct     = 30;
    rx_stall_pct    = 46;
    mismatch_count  = 0;
    samples_sent    = 0;
    results_checked = 0;
    settings_used   = 1;
    cycle_count     = 0;
    thr_model.cool_on  = COOL_ON_RST;
    thr_model.mid      = MID_RST;
    thr_model.high     = HIGH_RST;
    thr_model.overheat = OVERHEAT_RST;
    mode_model  = MODE_IDLE;
    alarm_model = 1'b0;

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_thresholds();
    test_unordered_thresholds();
    test_threshold_extremes();
    test_random_samples();

    drain_results();
    repeat (10) @(posedge clk_i);

    $display("sent %0d sensor samples under %0d threshold settings, checked %0d results",
             samples_sent, settings_used, results_checked);
    $display("stall mixes: sender-heavy, receiver-heavy and none; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
